// ===== hw/rtl/hmp_pkg.sv =====
`default_nettype none
package hmp_pkg;

  // Item kinds on the input side
  typedef enum logic [1:0] {
    CMD_DATA    = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_PAD     = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_LATE_DATA = 2'd1,
    ST_DONE      = 2'd2,
    ST_SATURATED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    STAGE_DATA   = 2'd0,
    STAGE_ZEROS  = 2'd1,
    STAGE_LENGTH = 2'd2,
    STAGE_FINISH = 2'd3
  } pad_stage_t;

  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_IS_128   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LENGTH_FIELD   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LITTLE_ENDIAN  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MARKER_BYTE    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PREFIX_BYTES   = 3'd4;

  localparam logic [5:0]  LENGTH_FIELD_RESET = 6'd8;
  localparam logic [7:0]  MARKER_RESET       = 8'h80;
  localparam logic [6:0]  LENGTH_FIELD_MIN   = 7'd8;

  typedef struct packed {
    logic        block_is_128;
    logic [5:0]  length_field_bytes;
    logic        length_little_endian;
    logic [7:0]  marker_byte;
    logic [31:0] prefix_bytes;
  } cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       pad_last;
    status_t    status;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/hmp_cfg.sv =====
`default_nettype none
module hmp_cfg import hmp_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_t                           cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_is_128         <= 1'b0;
      cfg.length_field_bytes   <= LENGTH_FIELD_RESET;
      cfg.length_little_endian <= 1'b1;
      cfg.marker_byte          <= MARKER_RESET;
      cfg.prefix_bytes         <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLOCK_IS_128:  cfg.block_is_128         <= cfg_data[0];
        REG_LENGTH_FIELD:  cfg.length_field_bytes   <= cfg_data[5:0];
        REG_LITTLE_ENDIAN: cfg.length_little_endian <= cfg_data[0];
        REG_MARKER_BYTE:   cfg.marker_byte          <= cfg_data[7:0];
        REG_PREFIX_BYTES:  cfg.prefix_bytes         <= cfg_data[31:0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hmp_core.sv =====
`default_nettype none
module hmp_core import hmp_pkg::*; #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire cmd_t       cmd,
  input  wire logic [7:0] data_byte,
  input  wire cfg_t       cfg,
  output result_t         res
);

  localparam int unsigned SUM_BITS = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 1;

  logic [COUNT_BITS-1:0] data_count, data_count_next;
  logic [7:0]            pad_emitted, pad_emitted_next;
  pad_stage_t            pad_stage, pad_stage_next;
  logic [2:0]            length_index, length_index_next;

  logic [SUM_BITS-1:0] total_bytes;
  logic [63:0]         len_bits;
  logic [2:0]          byte_sel;
  logic [6:0]          pos_mask;
  logic [6:0]          len_field;
  logic [6:0]          after_marker;
  logic [8:0]          first_run;
  logic [8:0]          zeros_needed;
  logic                zero_more;

  assign total_bytes = SUM_BITS'(cfg.prefix_bytes) + SUM_BITS'(data_count);
  assign len_bits    = 64'(total_bytes) << 3;
  assign byte_sel    = cfg.length_little_endian ? length_index : ~length_index;

  // Zero run: up to block - length field, then the extra field bytes down to block - 8
  assign pos_mask     = cfg.block_is_128 ? 7'h7F : 7'h3F;
  assign len_field    = ({1'b0, cfg.length_field_bytes} < LENGTH_FIELD_MIN) ?
                        LENGTH_FIELD_MIN : {1'b0, cfg.length_field_bytes};
  assign after_marker = (total_bytes[6:0] + 7'd1) & pos_mask;
  assign first_run    = ((cfg.block_is_128 ? 9'd256 : 9'd128) - {2'b0, len_field}
                         - {2'b0, after_marker}) & {2'b0, pos_mask};
  assign zeros_needed = first_run + {2'b0, len_field} - 9'd8;
  // pad_emitted wraps to zero only past any possible run, which ends the run
  assign zero_more    = (pad_emitted != 8'd0) &&
                        ({1'b0, pad_emitted - 8'd1} < zeros_needed);

  always_comb begin
    res               = '{out_byte: 8'd0, pad_last: 1'b0, status: ST_OK};
    data_count_next   = data_count;
    pad_emitted_next  = pad_emitted;
    pad_stage_next    = pad_stage;
    length_index_next = length_index;
    unique case (cmd)
      CMD_RESTART: begin
        data_count_next   = '0;
        pad_emitted_next  = '0;
        pad_stage_next    = STAGE_DATA;
        length_index_next = '0;
      end
      CMD_APPEND: begin
        res.out_byte = data_byte;
      end
      CMD_DATA: begin
        if (pad_stage != STAGE_DATA) begin
          res.status = ST_LATE_DATA;
        end else if (&data_count) begin
          res.status = ST_SATURATED;
        end else begin
          data_count_next = data_count + COUNT_BITS'(1);
          res.out_byte    = data_byte;
        end
      end
      CMD_PAD: begin
        if (pad_stage == STAGE_DATA) begin
          res.out_byte     = cfg.marker_byte;
          pad_emitted_next = 8'd1;
          pad_stage_next   = STAGE_ZEROS;
        end else if (pad_stage == STAGE_ZEROS && zero_more) begin
          pad_emitted_next = pad_emitted + 8'd1;
        end else if (pad_stage == STAGE_FINISH) begin
          res.status = ST_DONE;
        end else begin
          res.out_byte = len_bits[byte_sel*8 +: 8];
          if (length_index == 3'd7) begin
            res.pad_last      = 1'b1;
            pad_stage_next    = STAGE_FINISH;
            length_index_next = 3'd0;
          end else begin
            length_index_next = length_index + 3'd1;
            pad_stage_next    = STAGE_LENGTH;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_count   <= '0;
      pad_emitted  <= '0;
      pad_stage    <= STAGE_DATA;
      length_index <= '0;
    end else if (fire) begin
      data_count   <= data_count_next;
      pad_emitted  <= pad_emitted_next;
      pad_stage    <= pad_stage_next;
      length_index <= length_index_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hash_message_padder.sv =====
`default_nettype none
// Channel  Direction  Payload
// s_*      in         tdata = data_byte[7:0]; tuser = command[1:0]
// m_*      out        tdata = out_byte[7:0]; tlast = pad_last; tuser = status[1:0]
// cfg_*    in         write enable, register index, 32-bit write data
//
// One item per cycle sustained while m_tready stays high. An accepted item sits in the
// input register, then passes through the padding logic into the output register.
// Padding state is updated as the item moves from input to output register. rst is
// synchronous and clears both register valids, the padding state and the
// configuration. A stalled m_tready holds the output register and backs up into
// s_tready through the input register.
module hash_message_padder import hmp_pkg::*; #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [7:0]                s_tdata,   // [7:0] data_byte
  input  wire logic [1:0]                s_tuser,   // [1:0] command
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [7:0]                     m_tdata,   // [7:0] out_byte
  output logic                           m_tlast,
  output logic [1:0]                     m_tuser,   // [1:0] status
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  cfg_t       cfg;
  result_t    res;
  result_t    out_res;
  logic       in_full;
  cmd_t       in_cmd;
  logic [7:0] in_byte;
  logic       out_full;
  logic       proc;

  assign proc     = in_full && (!out_full || m_tready);
  assign s_tready = !in_full || proc;

  hmp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hmp_core #(.COUNT_BITS(COUNT_BITS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (proc),
    .cmd       (in_cmd),
    .data_byte (in_byte),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_full <= 1'b1;
    end else if (proc) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd  <= cmd_t'(s_tuser);
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (proc) begin
      out_full <= 1'b1;
    end else if (m_tready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_full;
  assign m_tdata  = out_res.out_byte;
  assign m_tlast  = out_res.pad_last;
  assign m_tuser  = out_res.status;

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import hmp_pkg::*;

  // Byte counter width of the padder under test
  localparam int unsigned COUNT_BITS = 16;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LIST [5] = '{
    REG_BLOCK_IS_128, REG_LENGTH_FIELD, REG_LITTLE_ENDIAN, REG_MARKER_BYTE, REG_PREFIX_BYTES
  };

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [7:0]                s_tdata = 8'h00;   // [7:0] data_byte
  logic [1:0]                s_tuser = CMD_DATA; // [1:0] command
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [7:0]                m_tdata;           // [7:0] out_byte
  logic                      m_tlast;
  logic [1:0]                m_tuser;           // [1:0] status
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  hash_message_padder #(.COUNT_BITS(COUNT_BITS)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Shadow of the padder: registers and padding state
  cfg_t                  cfg;
  logic [COUNT_BITS-1:0] msg_count = '0;
  logic [7:0]            fill_count = '0;
  pad_stage_t            pad_phase = STAGE_DATA;
  logic [2:0]            len_pos = '0;

  result_t     padded_q [$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned ready_hold = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("hash_message_padder regression: fail");
    $finish;
  end

  function automatic logic [7:0] rand8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void flag_mismatch(string what, int unsigned want, int unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
  endfunction

  // Zero bytes that follow the marker under the current register values
  function automatic int unsigned zeros_after_marker();
    int unsigned blk, lf, start, after, first;
    logic [63:0] pos;
    blk = cfg.block_is_128 ? 128 : 64;
    lf = 32'(cfg.length_field_bytes);
    if (lf < 8) lf = 8;
    if (lf > blk) lf = blk;
    pos = {32'b0, cfg.prefix_bytes} + 64'(msg_count);
    start = pos[31:0] & (blk - 1);
    after = (start + 1) & (blk - 1);
    first = ((blk - lf) + blk - after) & (blk - 1);
    return first + lf - 8;
  endfunction

  function automatic logic [7:0] len_bits_byte(logic [2:0] k);
    logic [63:0] bits;
    int unsigned shift;
    bits = ({32'b0, cfg.prefix_bytes} + 64'(msg_count)) << 3;
    shift = cfg.length_little_endian ? 8 * k : 56 - 8 * k;
    return 8'(bits >> shift);
  endfunction

  function automatic result_t next_padded_byte(cmd_t cmd, logic [7:0] value);
    result_t r;
    int unsigned filled;
    r.out_byte = 8'h00;
    r.pad_last = 1'b0;
    r.status = ST_OK;
    filled = 32'(fill_count);
    case (cmd)
      CMD_RESTART: begin
        msg_count = '0;
        fill_count = '0;
        pad_phase = STAGE_DATA;
        len_pos = '0;
      end
      CMD_APPEND: r.out_byte = value;
      CMD_DATA: begin
        if (pad_phase != STAGE_DATA) begin
          r.status = ST_LATE_DATA;
        end else if (&msg_count) begin
          r.status = ST_SATURATED;
        end else begin
          msg_count = msg_count + COUNT_BITS'(1);
          r.out_byte = value;
        end
      end
      default: begin
        if (pad_phase == STAGE_DATA) begin
          r.out_byte = cfg.marker_byte;
          fill_count = 8'd1;
          pad_phase = STAGE_ZEROS;
        end else if (pad_phase == STAGE_ZEROS && (filled - 1) < zeros_after_marker()) begin
          fill_count = fill_count + 8'd1;
        end else if (pad_phase == STAGE_FINISH) begin
          r.status = ST_DONE;
        end else begin
          r.out_byte = len_bits_byte(len_pos);
          if (len_pos == 3'd7) begin
            r.pad_last = 1'b1;
            pad_phase = STAGE_FINISH;
            len_pos = '0;
          end else begin
            len_pos = len_pos + 3'd1;
            pad_phase = STAGE_LENGTH;
          end
        end
      end
    endcase
    return r;
  endfunction

  // Result check and receiver-side idling
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (padded_q.size() == 0) begin
        flag_mismatch("result with nothing pending", 0, m_tdata);
      end else begin
        want = padded_q.pop_front();
        if (m_tdata !== want.out_byte) flag_mismatch("out_byte", want.out_byte, m_tdata);
        if (m_tlast !== want.pad_last) flag_mismatch("pad_last", want.pad_last, m_tlast);
        if (m_tuser !== want.status) flag_mismatch("status", want.status, m_tuser);
      end
    end
    if (ready_hold != 0) begin
      m_tready <= 1'b0;
      ready_hold = ready_hold - 1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_item(cmd_t cmd, logic [7:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    padded_q.push_back(next_padded_byte(cmd, value));
    items_sent++;
  endtask

  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    while (padded_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      REG_BLOCK_IS_128:  cfg.block_is_128 = value[0];
      REG_LENGTH_FIELD:  cfg.length_field_bytes = value[5:0];
      REG_LITTLE_ENDIAN: cfg.length_little_endian = value[0];
      REG_MARKER_BYTE:   cfg.marker_byte = value[7:0];
      REG_PREFIX_BYTES:  cfg.prefix_bytes = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Random register value, extremes favored; unused upper bits carry noise
  function automatic logic [31:0] pick_reg_value(logic [CFG_INDEX_BITS-1:0] index);
    logic [31:0] v;
    v = $urandom;
    case (index)
      REG_LENGTH_FIELD:
        case ($urandom_range(0, 7))
          0: v[5:0] = 6'd0;
          1: v[5:0] = 6'd7;
          2: v[5:0] = 6'd8;
          3: v[5:0] = 6'd32;
          4: v[5:0] = 6'd63;
          default: ;
        endcase
      REG_MARKER_BYTE:
        case ($urandom_range(0, 5))
          0: v[7:0] = 8'h80;
          1: v[7:0] = 8'h01;
          2: v[7:0] = 8'h00;
          3: v[7:0] = 8'hFF;
          default: ;
        endcase
      REG_PREFIX_BYTES:
        case ($urandom_range(0, 4))
          0: v = 32'h0000_0000;
          1: v = 32'hFFFF_FFFF;
          2: v = $urandom_range(0, 200);
          default: ;
        endcase
      default: ;
    endcase
    return v;
  endfunction

  task automatic write_random_reg();
    logic [CFG_INDEX_BITS-1:0] index;
    index = REG_LIST[$urandom_range(0, 4)];
    write_reg(index, pick_reg_value(index));
  endtask

  task automatic write_all_regs();
    foreach (REG_LIST[i]) write_reg(REG_LIST[i], pick_reg_value(REG_LIST[i]));
  endtask

  task automatic pad_to_end();
    while (pad_phase != STAGE_FINISH) send_item(CMD_PAD, rand8());
  endtask

  // One message: restart, then data and appends, padding, noise; or random items
  task automatic send_message();
    int unsigned style, n_data;
    style = $urandom_range(0, 9);
    send_item(CMD_RESTART, rand8());
    if (style == 0) begin
      repeat ($urandom_range(5, 40)) send_item(cmd_t'($urandom_range(0, 3)), rand8());
      return;
    end
    n_data = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 70);
    repeat (n_data) begin
      if ($urandom_range(0, 9) == 0) send_item(CMD_APPEND, rand8());
      else send_item(CMD_DATA, rand8());
    end
    while (pad_phase != STAGE_FINISH) begin
      if (style == 1 && pad_phase != STAGE_DATA && $urandom_range(0, 15) == 0) begin
        send_item(CMD_RESTART, rand8());
        return;
      end
      case ($urandom_range(0, 39))
        0: send_item(CMD_APPEND, rand8());
        1: send_item(CMD_DATA, rand8());
        2: begin
          // registers change while the zero run is going
          if (pad_phase == STAGE_ZEROS) begin
            wait_results_done();
            write_random_reg();
          end
        end
        default: send_item(CMD_PAD, rand8());
      endcase
    end
    repeat ($urandom_range(0, 3)) send_item(cmd_t'($urandom_range(0, 2)), rand8());
  endtask

  task automatic test_directed_cases();
    // secret plus data lands at 55 mod 64: marker straight into the length
    write_reg(REG_PREFIX_BYTES, 32'hFFFF_FFF3);
    write_reg(REG_MARKER_BYTE, 32'h0000_0001);
    send_item(CMD_DATA, 8'h00);
    send_item(CMD_DATA, 8'hFF);
    send_item(CMD_DATA, 8'h5A);
    send_item(CMD_DATA, 8'hA5);
    send_item(CMD_APPEND, 8'hFF);
    pad_to_end();
    send_item(CMD_PAD, 8'hFF);
    send_item(CMD_DATA, 8'h3C);
    send_item(CMD_APPEND, 8'h00);
    send_item(CMD_RESTART, 8'hFF);
    send_item(CMD_DATA, 8'h81);
    send_item(CMD_PAD, 8'h00);
    send_item(CMD_DATA, 8'h7E);
    send_item(CMD_RESTART, 8'h00);
    wait_results_done();
  endtask

  task automatic test_config_mid_padding();
    write_reg(REG_BLOCK_IS_128, 32'd0);
    write_reg(REG_LENGTH_FIELD, 32'd8);
    write_reg(REG_PREFIX_BYTES, 32'd0);
    send_item(CMD_RESTART, rand8());
    repeat (5) send_item(CMD_DATA, rand8());
    repeat (4) send_item(CMD_PAD, rand8());
    wait_results_done();
    // longer zero run under the new sizes
    write_reg(REG_BLOCK_IS_128, 32'd1);
    write_reg(REG_LENGTH_FIELD, 32'd63);
    repeat (20) send_item(CMD_PAD, rand8());
    wait_results_done();
    // zeros still short of the new need: the run goes on into the length bytes
    write_reg(REG_BLOCK_IS_128, 32'd0);
    write_reg(REG_LENGTH_FIELD, 32'd0);
    write_reg(REG_LITTLE_ENDIAN, 32'd0);
    pad_to_end();
    wait_results_done();
  endtask

  task automatic test_random_messages(int unsigned count);
    int unsigned goal;
    goal = items_sent + count;
    while (items_sent < goal) begin
      if ($urandom_range(0, 1) == 0) begin
        wait_results_done();
        write_all_regs();
      end
      send_message();
    end
    wait_results_done();
  endtask

  task automatic test_backpressure();
    send_item(CMD_RESTART, rand8());
    ready_hold = 400;
    repeat (40) send_item(($urandom_range(0, 3) == 0) ? CMD_APPEND : CMD_DATA, rand8());
    pad_to_end();
    wait_results_done();
  endtask

  initial begin
    cfg.block_is_128 = 1'b0;
    cfg.length_field_bytes = LENGTH_FIELD_RESET;
    cfg.length_little_endian = 1'b1;
    cfg.marker_byte = MARKER_RESET;
    cfg.prefix_bytes = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 21;
    recv_idle_pct = 67;
    test_directed_cases();
    test_config_mid_padding();
    test_random_messages(650);

    send_idle_pct = 67;
    recv_idle_pct = 21;
    test_random_messages(650);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_messages(650);
    test_backpressure();

    wait_results_done();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && padded_q.size() == 0) begin
      $display("hash_message_padder regression: pass");
    end else begin
      $display("hash_message_padder regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/hmp_pkg.sv
hw/rtl/hmp_cfg.sv
hw/rtl/hmp_core.sv
hw/rtl/hash_message_padder.sv
test/testbench.sv
